// ===== rtl/core/ted_pkg.sv =====
// Shared types, constants and lookup functions for the transfer encoding decoder.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package ted_pkg;

   // Decoding modes held in the mode register.
   typedef enum logic [1:0] {
      MODE_PASS   = 2'd0,
      MODE_BASE64 = 2'd1,
      MODE_QP     = 2'd2,
      MODE_QWORD  = 2'd3
   } mode_type;

   // Progress through a quoted-printable escape.
   typedef enum logic [1:0] {
      ESC_NONE  = 2'd0,
      ESC_EQ    = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_type;

   // Register index of the mode register (word address bit of paddr).
   localparam logic RegDecodeMode = 1'b0;

   // Characters with a special meaning.
   localparam logic [7:0] CharEq    = 8'h3D;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharUnder = 8'h5F;
   localparam logic [7:0] CharSpace = 8'h20;

   // Group queue between the front and back ends.
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // All results caused by one request: one to three bytes.
   typedef struct packed {
      logic [1:0]      cnt;     // number of results, 1 to 3
      logic [2:0][7:0] data;    // result bytes, index 0 first
      logic            marker;  // empty end marker, no data
      logic            last;    // the group closes the stream
   } group_type;

   // Hex digit value: bit 4 set when the character is a hex digit.
   function automatic logic [4:0] hex_lookup(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   // Base64 sextet value: bit 6 set when the character is in the alphabet.
   function automatic logic [6:0] b64_lookup(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ted_front.sv =====
// Front end: accepts requests, keeps the decoding state and forms a result group.
// Uses ted_pkg types and lookup functions; feeds ted_queue.
`default_nettype none

module ted_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ted_pkg::mode_type    mode,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   input  wire logic                 q_full,
   output logic                      q_push,
   output ted_pkg::group_type        q_group
);

   logic [11:0]      bit_buffer_ff,    bit_buffer_in;
   logic [2:0]       bit_count_ff,     bit_count_in;
   ted_pkg::esc_type escape_phase_ff,  escape_phase_in;
   logic [7:0]       held_digit_ff,    held_digit_in;
   logic             after_soft_cr_ff, after_soft_cr_in;

   logic             accept;
   logic [1:0]       emit_cnt;
   logic [2:0][7:0]  emit_data;
   logic             marker;
   logic             drop_lf;
   logic [8:0]       plain;
   logic [4:0]       hex_c;
   logic [4:0]       hex_h;
   logic [6:0]       b64_c;
   logic [11:0]      shifted;
   logic [3:0]       count_sum;

   // A plain byte: bit 8 flags an opening '=', else the mapped byte.
   function automatic logic [8:0] plain_map(input logic [7:0] c,
                                            input ted_pkg::mode_type m);
      logic [8:0] r;
      r = {1'b0, c};
      if (c == ted_pkg::CharEq) begin
         r = {1'b1, c};
      end else if (m == ted_pkg::MODE_QWORD && c == ted_pkg::CharUnder) begin
         r = {1'b0, ted_pkg::CharSpace};
      end
      return r;
   endfunction

   // The front only holds back when the group queue is full.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   assign plain = plain_map(req_data_byte, mode);
   assign hex_c = ted_pkg::hex_lookup(req_data_byte);
   assign hex_h = ted_pkg::hex_lookup(held_digit_ff);
   assign b64_c = ted_pkg::b64_lookup(req_data_byte);

   // Decode one request into up to three result bytes and the next state.
   always_comb begin
      bit_buffer_in    = bit_buffer_ff;
      bit_count_in     = bit_count_ff;
      escape_phase_in  = escape_phase_ff;
      held_digit_in    = held_digit_ff;
      after_soft_cr_in = after_soft_cr_ff;
      emit_cnt         = 2'd0;
      emit_data        = '0;
      drop_lf          = 1'b0;
      shifted          = 12'd0;
      count_sum        = 4'd0;
      marker           = 1'b0;

      unique case (mode)
         ted_pkg::MODE_PASS: begin
            emit_data[emit_cnt] = req_data_byte;
            emit_cnt = emit_cnt + 2'd1;
         end
         ted_pkg::MODE_BASE64: begin
            if (b64_c[6]) begin
               bit_buffer_in = {bit_buffer_ff[5:0], b64_c[5:0]};
               count_sum = {1'b0, bit_count_ff} + 4'd6;
               if (count_sum >= 4'd8) begin
                  bit_count_in = 3'(count_sum - 4'd8);
                  shifted = bit_buffer_in >> bit_count_in;
                  emit_data[emit_cnt] = shifted[7:0];
                  emit_cnt = emit_cnt + 2'd1;
               end else begin
                  bit_count_in = count_sum[2:0];
               end
            end
         end
         ted_pkg::MODE_QP, ted_pkg::MODE_QWORD: begin
            // One LF after a soft "=" CR break is swallowed.
            if (after_soft_cr_ff) begin
               after_soft_cr_in = 1'b0;
               drop_lf = (req_data_byte == ted_pkg::CharLf);
            end
            if (!drop_lf) begin
               case (escape_phase_ff)
                  ted_pkg::ESC_NONE: begin
                     if (plain[8]) begin
                        escape_phase_in = ted_pkg::ESC_EQ;
                     end else begin
                        emit_data[emit_cnt] = plain[7:0];
                        emit_cnt = emit_cnt + 2'd1;
                     end
                  end
                  ted_pkg::ESC_EQ: begin
                     if (mode == ted_pkg::MODE_QP &&
                         (req_data_byte == ted_pkg::CharCr ||
                          req_data_byte == ted_pkg::CharLf)) begin
                        // Soft line break.
                        escape_phase_in  = ted_pkg::ESC_NONE;
                        after_soft_cr_in = (req_data_byte == ted_pkg::CharCr);
                     end else if (hex_c[4]) begin
                        held_digit_in   = req_data_byte;
                        escape_phase_in = ted_pkg::ESC_DIGIT;
                     end else begin
                        // Malformed escape: '=' comes out as it stands.
                        emit_data[emit_cnt] = ted_pkg::CharEq;
                        emit_cnt = emit_cnt + 2'd1;
                        escape_phase_in = ted_pkg::ESC_NONE;
                        if (plain[8]) begin
                           escape_phase_in = ted_pkg::ESC_EQ;
                        end else begin
                           emit_data[emit_cnt] = plain[7:0];
                           emit_cnt = emit_cnt + 2'd1;
                        end
                     end
                  end
                  ted_pkg::ESC_DIGIT: begin
                     escape_phase_in = ted_pkg::ESC_NONE;
                     if (hex_c[4] && hex_h[4]) begin
                        emit_data[emit_cnt] = {hex_h[3:0], hex_c[3:0]};
                        emit_cnt = emit_cnt + 2'd1;
                     end else begin
                        // Malformed escape: '=' and the held digit come out.
                        emit_data[emit_cnt] = ted_pkg::CharEq;
                        emit_cnt = emit_cnt + 2'd1;
                        emit_data[emit_cnt] = held_digit_ff;
                        emit_cnt = emit_cnt + 2'd1;
                        if (plain[8]) begin
                           escape_phase_in = ted_pkg::ESC_EQ;
                        end else begin
                           emit_data[emit_cnt] = plain[7:0];
                           emit_cnt = emit_cnt + 2'd1;
                        end
                     end
                  end
                  default: begin
                     escape_phase_in = ted_pkg::ESC_NONE;
                  end
               endcase
            end
         end
         default: begin
            emit_cnt = 2'd0;
         end
      endcase

      // End of stream: flush a pending escape, clear all state.
      if (req_last_byte) begin
         if (mode == ted_pkg::MODE_QP || mode == ted_pkg::MODE_QWORD) begin
            if (escape_phase_in == ted_pkg::ESC_EQ ||
                escape_phase_in == ted_pkg::ESC_DIGIT) begin
               if (emit_cnt != 2'd3) begin
                  emit_data[emit_cnt] = ted_pkg::CharEq;
                  emit_cnt = emit_cnt + 2'd1;
               end
            end
            if (escape_phase_in == ted_pkg::ESC_DIGIT) begin
               if (emit_cnt != 2'd3) begin
                  emit_data[emit_cnt] = held_digit_in;
                  emit_cnt = emit_cnt + 2'd1;
               end
            end
         end
         bit_buffer_in    = 12'd0;
         bit_count_in     = 3'd0;
         escape_phase_in  = ted_pkg::ESC_NONE;
         held_digit_in    = 8'd0;
         after_soft_cr_in = 1'b0;
         if (emit_cnt == 2'd0) begin
            marker   = 1'b1;
            emit_cnt = 2'd1;
         end
      end
   end

   // Hand the group to the queue whenever the request produced a result.
   assign q_push         = accept && (emit_cnt != 2'd0);
   assign q_group.cnt    = emit_cnt;
   assign q_group.data   = emit_data;
   assign q_group.marker = marker;
   assign q_group.last   = req_last_byte;

   // Decoding state advances on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff    <= 12'd0;
         bit_count_ff     <= 3'd0;
         escape_phase_ff  <= ted_pkg::ESC_NONE;
         held_digit_ff    <= 8'd0;
         after_soft_cr_ff <= 1'b0;
      end else if (accept) begin
         bit_buffer_ff    <= bit_buffer_in;
         bit_count_ff     <= bit_count_in;
         escape_phase_ff  <= escape_phase_in;
         held_digit_ff    <= held_digit_in;
         after_soft_cr_ff <= after_soft_cr_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ted_queue.sv =====
// Short queue of result groups between the front and back ends.
// Uses ted_pkg for the group type and depth constants.
`default_nettype none

module ted_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ted_pkg::group_type push_group,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output ted_pkg::group_type      head
);

   ted_pkg::group_type                entry_ff [ted_pkg::QDepth];
   logic [ted_pkg::QPtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ted_pkg::QPtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ted_pkg::QCntW-1:0]         count_ff,  count_in;

   assign full      = (count_ff == ted_pkg::QCntW'(ted_pkg::QDepth));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + ted_pkg::QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + ted_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + ted_pkg::QCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - ted_pkg::QCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Group storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ted_back.sv =====
// Back end: unrolls each queued group into single results behind an output register.
// Uses ted_pkg for the group type; drains ted_queue.
`default_nettype none

module ted_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire ted_pkg::group_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_out_valid,
   output logic                    rsp_run_last,
   output logic                    rsp_stream_end
);

   logic [1:0] idx_ff,            idx_in;
   logic       rsp_valid_ff,      rsp_valid_in;
   logic [7:0] rsp_out_byte_ff,   rsp_out_byte_in;
   logic       rsp_out_valid_ff,  rsp_out_valid_in;
   logic       rsp_run_last_ff,   rsp_run_last_in;
   logic       rsp_stream_end_ff, rsp_stream_end_in;
   logic       load;
   logic       group_done;

   // The output register takes a new result when empty or being taken.
   assign load       = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign group_done = (idx_ff == head.cnt - 2'd1);
   assign pop        = load && group_done;

   always_comb begin
      idx_in            = idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_out_valid_in  = rsp_out_valid_ff;
      rsp_run_last_in   = rsp_run_last_ff;
      rsp_stream_end_in = rsp_stream_end_ff;
      if (load) begin
         rsp_valid_in      = 1'b1;
         rsp_out_byte_in   = head.marker ? 8'd0 : head.data[idx_ff];
         rsp_out_valid_in  = !head.marker;
         rsp_run_last_in   = group_done;
         rsp_stream_end_in = group_done && head.last;
         idx_in            = group_done ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_out_valid_ff  <= rsp_out_valid_in;
      rsp_run_last_ff   <= rsp_run_last_in;
      rsp_stream_end_ff <= rsp_stream_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_stream_end = rsp_stream_end_ff;

   // The position within a group stays inside that group.
   assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff < head.cnt))
      else $error("result index beyond the group size");

   // A group is never left part-way through with the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> head_valid)
      else $error("group unrolling lost its queue entry");

   // The end of the stream is always the last result of its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stream_end_ff) |-> rsp_run_last_ff)
      else $error("stream end without run last");

   // An end marker carries a zero byte and closes the stream.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_out_valid_ff) |->
         (rsp_out_byte_ff == 8'd0 && rsp_stream_end_ff))
      else $error("malformed end marker");

endmodule

`default_nettype wire

// ===== rtl/core/transfer_encoding_decoder.sv =====
// Transfer encoding decoder top level: mode register, front end, group queue, back end.
// Depends on ted_pkg, ted_front, ted_queue and ted_back.
//
// Usage. Encoded bytes arrive one per request on the req_ channel (data byte and a
// last-byte flag). Each request yields zero to three results on the rsp_ channel;
// a request that closes the stream always yields at least one (an end marker with
// rsp_out_valid low when nothing else came out). rsp_run_last marks the final
// result of a request and rsp_stream_end the final result of the stream.
// The decoding mode is set over the register port while the block is idle.
// Timing. A request is decoded in the cycle it is accepted; its results pass through
// the group queue into the output register. One request is taken per cycle; the
// output side delivers one result per cycle, so requests that expand to several
// results are absorbed by a four-group queue, and req_stall rises only when it
// is full. A stall on rsp_ holds the output register and fills the queue.
// Reset clears the mode to pass-through, all decoding state and the queue.
`default_nettype none

module transfer_encoding_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic             rsp_run_last,
   output logic             rsp_stream_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [1:0]         decode_mode_ff, decode_mode_in;
   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_not_empty;
   ted_pkg::group_type q_in_group;
   ted_pkg::group_type q_head;

   // Register port: one mode register at word zero.
   assign pready = 1'b1;
   always_comb begin
      decode_mode_in = decode_mode_ff;
      if (psel && penable && pwrite && paddr[2] == ted_pkg::RegDecodeMode) begin
         decode_mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decode_mode_ff <= 2'd0;
      end else begin
         decode_mode_ff <= decode_mode_in;
      end
   end

   assign prdata = (paddr[2] == ted_pkg::RegDecodeMode) ? {30'd0, decode_mode_ff} : 32'd0;

   ted_front u_front (
      .clock         (clock),
      .reset         (reset),
      .mode          (ted_pkg::mode_type'(decode_mode_ff)),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_group       (q_in_group)
   );

   ted_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_group (q_in_group),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   ted_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_not_empty),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule

`default_nettype wire

// ===== test/tb_transfer_encoding_decoder.sv =====
// Self-checking testbench for transfer_encoding_decoder: directed and random byte streams
// in all four decoding modes, checked against a predictor of the decoding rules.
// Depends on ted_pkg and the transfer_encoding_decoder RTL.
`default_nettype none

module tb_transfer_encoding_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   // Register addresses: the mode register and an unused word beside it.
   localparam logic [2:0] AddrMode  = {ted_pkg::RegDecodeMode, 2'b00};
   localparam logic [2:0] AddrSpare = {~ted_pkg::RegDecodeMode, 2'b00};

   localparam int CycleLimit   = 200000;
   localparam int SettleCycles = 8;
   localparam int LongHold     = 60;
   localparam int RandomItems  = 340;
   localparam int QuietFrom    = 300;
   localparam int MaxPerItem   = 3;

   // One decoded byte or end marker as it appears on the response channel.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       run_last;
      logic       stream_end;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic        rsp_run_last;
   logic        rsp_stream_end;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   transfer_encoding_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_valid  (rsp_out_valid),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: a private copy of the mode register and the decoding state.
   ted_pkg::mode_type cur_mode = ted_pkg::MODE_PASS;
   logic [11:0]       b64_bits = '0;
   int                b64_count = 0;
   ted_pkg::esc_type  esc = ted_pkg::ESC_NONE;
   logic [7:0]        held = '0;
   logic              soft_cr = 1'b0;

   decoded_type batch [MaxPerItem];
   int          batch_n;
   decoded_type expected_bytes [$];

   logic [7:0]  stream_bytes [$];
   int          items_sent = 0;
   int          idle_pct = 0;
   int          long_holds_asked = 0;
   int          failures = 0;
   int          cycle_count = 0;

   function automatic void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   // Value of a hexadecimal digit in either case, or -1.
   function automatic int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   // Six-bit value of a base64 alphabet character, or -1 for any other byte.
   function automatic int sextet_of(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   function automatic void put(logic [7:0] b, logic v);
      if (batch_n < MaxPerItem) begin
         batch[batch_n] = '{data: b, valid: v, run_last: 1'b0, stream_end: 1'b0};
         batch_n++;
      end
   endfunction

   // A byte met with no escape under way.
   function automatic void plain_char(logic [7:0] c);
      if (c == ted_pkg::CharEq) begin
         esc = ted_pkg::ESC_EQ;
      end else if (cur_mode == ted_pkg::MODE_QWORD && c == ted_pkg::CharUnder) begin
         put(ted_pkg::CharSpace, 1'b1);
      end else begin
         put(c, 1'b1);
      end
   endfunction

   function automatic void qp_char(logic [7:0] c);
      int hi;
      int lo;
      // The byte after a soft "=" CR is dropped only if it is LF.
      if (soft_cr) begin
         soft_cr = 1'b0;
         if (c == ted_pkg::CharLf) return;
      end
      case (esc)
         ted_pkg::ESC_NONE: begin
            plain_char(c);
         end
         ted_pkg::ESC_EQ: begin
            if (cur_mode == ted_pkg::MODE_QP &&
                (c == ted_pkg::CharCr || c == ted_pkg::CharLf)) begin
               esc = ted_pkg::ESC_NONE;
               soft_cr = (c == ted_pkg::CharCr);
            end else if (hex_digit(c) >= 0) begin
               held = c;
               esc = ted_pkg::ESC_DIGIT;
            end else begin
               put(ted_pkg::CharEq, 1'b1);
               esc = ted_pkg::ESC_NONE;
               plain_char(c);
            end
         end
         default: begin
            hi = hex_digit(held);
            lo = hex_digit(c);
            if (hi >= 0 && lo >= 0) begin
               put({hi[3:0], lo[3:0]}, 1'b1);
               esc = ted_pkg::ESC_NONE;
            end else begin
               put(ted_pkg::CharEq, 1'b1);
               put(held, 1'b1);
               esc = ted_pkg::ESC_NONE;
               plain_char(c);
            end
         end
      endcase
   endfunction

   function automatic void b64_char(logic [7:0] c);
      int v;
      v = sextet_of(c);
      if (v < 0) return;
      b64_bits = {b64_bits[5:0], v[5:0]};
      b64_count += 6;
      if (b64_count >= 8) begin
         b64_count -= 8;
         put(8'(b64_bits >> b64_count), 1'b1);
      end
   endfunction

   // Works out the results of one accepted request and queues them.
   function automatic void decode_expected(logic [7:0] c, logic last);
      batch_n = 0;
      case (cur_mode)
         ted_pkg::MODE_PASS:   put(c, 1'b1);
         ted_pkg::MODE_BASE64: b64_char(c);
         default:              qp_char(c);
      endcase
      if (last) begin
         // A pending escape comes out literally; leftover base64 bits are lost.
         if (cur_mode == ted_pkg::MODE_QP || cur_mode == ted_pkg::MODE_QWORD) begin
            if (esc != ted_pkg::ESC_NONE) put(ted_pkg::CharEq, 1'b1);
            if (esc == ted_pkg::ESC_DIGIT) put(held, 1'b1);
         end
         b64_bits = '0;
         b64_count = 0;
         esc = ted_pkg::ESC_NONE;
         held = '0;
         soft_cr = 1'b0;
         if (batch_n == 0) put(8'h00, 1'b0);
         batch[batch_n - 1].stream_end = 1'b1;
      end
      if (batch_n > 0) batch[batch_n - 1].run_last = 1'b1;
      for (int k = 0; k < batch_n; k++) begin
         expected_bytes.push_back(batch[k]);
      end
   endfunction

   // Offers one request, with an occasional gap first, and holds it until taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data_byte = b;
      req_last_byte = last;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      decode_expected(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream(input bit close);
      foreach (stream_bytes[k]) begin
         send_byte(stream_bytes[k], close && k == stream_bytes.size() - 1);
      end
   endtask

   // Stops offering and waits until every expected result has come back.
   task automatic settle_results();
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = wr;
      paddr = addr;
      pwdata = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Changes the mode once the block is idle, then reads it back.
   task automatic set_mode(input ted_pkg::mode_type m);
      logic [31:0] rd;
      settle_results();
      csr_access(1'b1, AddrMode, ($urandom() & ~32'h3) | 32'(m), rd);
      cur_mode = m;
      csr_access(1'b0, AddrMode, '0, rd);
      if (rd !== 32'(m)) begin
         note_failure($sformatf("mode read-back: expected %0d, got %08h", m, rd));
      end
   endtask

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'("0" + v);
      return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
   endfunction

   function automatic logic [7:0] alphabet_char(int v);
      if (v < 26) return 8'("A" + v);
      if (v < 52) return 8'("a" + v - 26);
      if (v < 62) return 8'("0" + v - 52);
      return (v == 62) ? 8'("+") : 8'("/");
   endfunction

   // Fills stream_bytes with mostly well-formed text for the mode, cut to len bytes.
   task automatic build_stream(input ted_pkg::mode_type m, input int len);
      int r;
      stream_bytes.delete();
      while (stream_bytes.size() < len) begin
         r = $urandom_range(0, 99);
         if (m == ted_pkg::MODE_PASS) begin
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (m == ted_pkg::MODE_BASE64) begin
            if (r < 88) stream_bytes.push_back(alphabet_char($urandom_range(0, 63)));
            else if (r < 93) stream_bytes.push_back(ted_pkg::CharEq);
            else if (r < 97) begin
               stream_bytes.push_back($urandom_range(0, 1) ? ted_pkg::CharCr
                                                           : ted_pkg::CharLf);
            end
            else stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 45) begin
            stream_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (r < 65) begin
            stream_bytes.push_back(ted_pkg::CharEq);
            stream_bytes.push_back(hex_char($urandom_range(0, 15)));
            stream_bytes.push_back(hex_char($urandom_range(0, 15)));
         end else if (r < 75) begin
            // Soft line breaks: "=" CR LF, "=" LF, or "=" CR alone.
            stream_bytes.push_back(ted_pkg::CharEq);
            case ($urandom_range(0, 2))
               0: begin
                  stream_bytes.push_back(ted_pkg::CharCr);
                  stream_bytes.push_back(ted_pkg::CharLf);
               end
               1: stream_bytes.push_back(ted_pkg::CharLf);
               default: stream_bytes.push_back(ted_pkg::CharCr);
            endcase
         end else if (r < 82) begin
            stream_bytes.push_back(ted_pkg::CharEq);
            stream_bytes.push_back(hex_char($urandom_range(0, 15)));
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 88) begin
            stream_bytes.push_back(ted_pkg::CharEq);
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else if (r < 94) begin
            stream_bytes.push_back(ted_pkg::CharUnder);
         end else begin
            stream_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
      while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
   endtask

   // Every mode value written and read back; a write to the spare word is ignored.
   task automatic test_register_port();
      logic [31:0] rd;
      for (int k = 3; k >= 0; k--) set_mode(ted_pkg::mode_type'(k));
      csr_access(1'b1, AddrSpare, 32'(ted_pkg::MODE_QWORD), rd);
      csr_access(1'b0, AddrMode, '0, rd);
      if (rd !== 32'(cur_mode)) begin
         note_failure($sformatf("spare write changed mode: got %08h", rd));
      end
   endtask

   task automatic test_pass_through();
      set_mode(ted_pkg::MODE_PASS);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(ted_pkg::CharUnder, 1'b1);
   endtask

   // "Man", skipped padding and junk, then leftover bits dropped with an end marker.
   task automatic test_base64();
      set_mode(ted_pkg::MODE_BASE64);
      send_byte("T", 1'b0);
      send_byte("W", 1'b0);
      send_byte("F", 1'b0);
      send_byte("u", 1'b0);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte("/", 1'b1);
   endtask

   // Lower/upper hex escape, soft break, bad second digit, escape cut by end of stream.
   task automatic test_quoted_printable();
      set_mode(ted_pkg::MODE_QP);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte("a", 1'b0);
      send_byte("F", 1'b0);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte(ted_pkg::CharCr, 1'b0);
      send_byte(ted_pkg::CharLf, 1'b0);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte("4", 1'b0);
      send_byte("x", 1'b0);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte("4", 1'b1);
   endtask

   // Underscore becomes space, and "=" CR is not a soft break here.
   task automatic test_qword();
      set_mode(ted_pkg::MODE_QWORD);
      send_byte(ted_pkg::CharUnder, 1'b0);
      send_byte(ted_pkg::CharEq, 1'b0);
      send_byte(ted_pkg::CharCr, 1'b1);
   endtask

   // The receiver holds off long enough for the queue to fill and stall requests.
   task automatic test_backpressure();
      set_mode(ted_pkg::MODE_PASS);
      idle_pct = 0;
      long_holds_asked++;
      repeat (24) send_byte(8'($urandom_range(0, 255)), 1'b0);
      settle_results();
      for (int k = 0; k < 16; k++) send_byte(8'($urandom_range(0, 255)), k == 15);
   endtask

   // Random streams in random modes; the last stretch runs without idling.
   task automatic test_random_streams();
      int start;
      ted_pkg::mode_type m;
      start = items_sent;
      while (items_sent - start < RandomItems) begin
         m = ted_pkg::mode_type'($urandom_range(0, 3));
         set_mode(m);
         repeat ($urandom_range(1, 4)) begin
            if (items_sent - start >= QuietFrom) idle_pct = 0;
            else idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 15;
            build_stream(m, $urandom_range(1, 24));
            send_stream($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 9) == 0) settle_results();
         end
      end
   endtask

   // Receiver: random stall bursts, plus a long hold whenever one is asked for.
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_holds_asked > holds_done) begin
            holds_done++;
            rsp_stall = 1'b1;
            repeat (LongHold) @(negedge clock);
         end
         if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Each accepted result is compared with the oldest expected one.
   always @(posedge clock) begin
      decoded_type want;
      decoded_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_byte, rsp_out_valid, rsp_run_last, rsp_stream_end};
         if (expected_bytes.size() == 0) begin
            note_failure($sformatf("unexpected result: byte %02h valid %0b run_last %0b end %0b",
                                   got.data, got.valid, got.run_last, got.stream_end));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want) begin
               note_failure($sformatf({"result mismatch: expected byte %02h valid %0b ",
                                       "run_last %0b end %0b, got byte %02h valid %0b ",
                                       "run_last %0b end %0b"},
                                      want.data, want.valid, want.run_last, want.stream_end,
                                      got.data, got.valid, got.run_last, got.stream_end));
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_last_byte = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_pct = 15;
      test_register_port();
      test_pass_through();
      test_base64();
      test_quoted_printable();
      test_qword();
      test_backpressure();
      test_random_streams();

      settle_results();
      repeat (20) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         note_failure($sformatf("%0d expected results never arrived", expected_bytes.size()));
      end
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/ted_pkg.sv
rtl/core/ted_front.sv
rtl/core/ted_queue.sv
rtl/core/ted_back.sv
rtl/core/transfer_encoding_decoder.sv
test/tb_transfer_encoding_decoder.sv
